// ----- sv/rpd_pkg.sv -----
// ----------------------------------------------------------------------------
// rpd_pkg
// shared types and constants of the remote-debug packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  // result kinds
  localparam logic [1:0] EV_RUN        = 2'd0;
  localparam logic [1:0] EV_END        = 2'd1;
  localparam logic [1:0] EV_BREAK      = 2'd2;
  localparam logic [1:0] EV_UNEXPECTED = 2'd3;

  // framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_BREAK  = 8'h03;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [7:0] RUN_BIAS  = 8'd29;
  localparam logic [7:0] BODY_MAX  = 8'd126;

  // hex digit bounds
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] HEX_TEN = 8'd10;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] count;
    logic       ok;
  } rpd_evt_t;

endpackage

`default_nettype wire

// ----- sv/rpd_front.sv -----
// ----------------------------------------------------------------------------
// rpd_front
// accepts received bytes, tracks the packet phase and checksum, and
// classifies each byte into at most one result pushed to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_front import rpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output rpd_evt_t        q_evt
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_BODY, PH_ESCAPE, PH_RUNLEN, PH_END, PH_CHECKSUM
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [7:0] last_byte, last_byte_next;
  logic       nonempty, nonempty_next;

  logic       take;
  logic       emit;
  rpd_evt_t   evt;
  logic       hex_ok;
  logic [7:0] hex_full;
  logic [3:0] hex_val;
  logic [7:0] esc_byte;
  logic [7:0] run_count;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign esc_byte = rx_byte ^ ESC_MASK;
  assign run_count = rx_byte - RUN_BIAS;

  always_comb begin
    hex_ok   = 1'b1;
    hex_full = 8'd0;
    if (rx_byte inside {[CH_0:CH_9]}) begin
      hex_full = rx_byte - CH_0;
    end else if (rx_byte inside {[CH_UA:CH_UF]}) begin
      hex_full = rx_byte - CH_UA + HEX_TEN;
    end else if (rx_byte inside {[CH_LA:CH_LF]}) begin
      hex_full = rx_byte - CH_LA + HEX_TEN;
    end else begin
      hex_ok = 1'b0;
    end
    hex_val = hex_full[3:0];
  end

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    high_nibble_next = high_nibble;
    last_byte_next   = last_byte;
    nonempty_next    = nonempty;
    emit             = 1'b0;
    evt              = '{kind: EV_UNEXPECTED, data: rx_byte, count: 8'd0, ok: 1'b0};

    if ((phase == PH_BODY && rx_byte != CH_HASH) || phase == PH_ESCAPE ||
        phase == PH_RUNLEN) begin
      running_sum_next = running_sum + rx_byte;
    end

    case (phase)
      PH_BODY: begin
        if (rx_byte == CH_RBRACE) begin
          phase_next = PH_ESCAPE;
        end else if (rx_byte == CH_HASH) begin
          phase_next = PH_END;
        end else if (rx_byte == CH_STAR) begin
          phase_next = PH_RUNLEN;
        end else if (rx_byte > BODY_MAX) begin
          emit = 1'b1;
        end else begin
          emit           = 1'b1;
          evt            = '{kind: EV_RUN, data: rx_byte, count: 8'd1, ok: 1'b0};
          last_byte_next = rx_byte;
          nonempty_next  = 1'b1;
        end
      end
      PH_ESCAPE: begin
        phase_next     = PH_BODY;
        emit           = 1'b1;
        evt            = '{kind: EV_RUN, data: esc_byte, count: 8'd1, ok: 1'b0};
        last_byte_next = esc_byte;
        nonempty_next  = 1'b1;
      end
      PH_RUNLEN: begin
        phase_next = PH_BODY;
        if (rx_byte > RUN_BIAS && nonempty) begin
          emit = 1'b1;
          evt  = '{kind: EV_RUN, data: last_byte, count: run_count, ok: 1'b0};
        end
      end
      PH_END: begin
        if (!hex_ok) begin
          emit = 1'b1;
        end else begin
          high_nibble_next = hex_val;
          phase_next       = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        if (!hex_ok) begin
          emit = 1'b1;
        end else begin
          emit             = 1'b1;
          evt              = '{kind: EV_END, data: 8'd0, count: 8'd0,
                               ok: ({high_nibble, hex_val} == running_sum)};
          phase_next       = PH_IDLE;
          running_sum_next = 8'd0;
          high_nibble_next = 4'd0;
          last_byte_next   = 8'd0;
          nonempty_next    = 1'b0;
        end
      end
      default: begin
        if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
          emit = 1'b0;
        end else if (rx_byte == CH_DOLLAR) begin
          phase_next = PH_BODY;
        end else if (rx_byte == CH_BREAK) begin
          emit = 1'b1;
          evt  = '{kind: EV_BREAK, data: 8'd0, count: 8'd0, ok: 1'b0};
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

  assign q_push = take && emit;
  assign q_evt  = evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_sum <= 8'd0;
      high_nibble <= 4'd0;
      last_byte   <= 8'd0;
      nonempty    <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      high_nibble <= high_nibble_next;
      last_byte   <= last_byte_next;
      nonempty    <= nonempty_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rpd_queue.sv -----
// ----------------------------------------------------------------------------
// rpd_queue
// short result queue that decouples the classifier from the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_queue import rpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire rpd_evt_t push_evt,
  input  wire logic     pop,
  output rpd_evt_t      head_evt,
  output logic          full,
  output logic          empty
);

  rpd_evt_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  assign full     = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_evt = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("request pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("request popped from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ----- sv/rpd_back.sv -----
// ----------------------------------------------------------------------------
// rpd_back
// output stage: drains the queue into a registered valid/ready result port
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_back import rpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_empty,
  input  wire rpd_evt_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [1:0]    event_kind,
  output logic [7:0]    data_byte,
  output logic [7:0]    repeat_count,
  output logic          checksum_ok
);

  rpd_evt_t hold;

  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold <= q_head;
    end
  end

  assign event_kind   = hold.kind;
  assign data_byte    = hold.data;
  assign repeat_count = hold.count;
  assign checksum_ok  = hold.ok;

endmodule

`default_nettype wire

// ----- sv/rsp_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// rsp_packet_deframer
// remote-debug serial packet deframer: one received byte per request in,
// body runs, packet ends, breaks and unexpected bytes out
// ----------------------------------------------------------------------------
// a result is written to the queue and then to the output register before it is valid at the output
// throughput: one byte per cycle while the queue is not full, set by the combinational classifier step
// a four-entry queue and the output register absorb output stalls
// reset: synchronous, clears phase, checksum, queue and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_packet_deframer import rpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      event_kind,
  output logic [7:0]      data_byte,
  output logic [7:0]      repeat_count,
  output logic            checksum_ok
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  rpd_evt_t push_evt;
  rpd_evt_t head_evt;

  rpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_evt    (push_evt)
  );

  rpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_evt (push_evt),
    .pop      (q_pop),
    .head_evt (head_evt),
    .full     (q_full),
    .empty    (q_empty)
  );

  rpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (head_evt),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .data_byte    (data_byte),
    .repeat_count (repeat_count),
    .checksum_ok  (checksum_ok)
  );

endmodule

`default_nettype wire

// ----- tb/sv/rsp_packet_deframer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsp_packet_deframer_test
// Self-checking bench for the packet deframer. Bytes go in as framed packets
// with random bodies (runs, escapes, high bytes, corrupted and malformed
// checksums) and as loose noise outside packets. A scoreboard tracks the
// framing state, predicts each event and compares it field by field with the
// block's output. Both sides idle at random, and the output side also holds
// off for a long stretch to back up the block.
// ----------------------------------------------------------------------------

module rsp_packet_deframer_test;
  import rpd_pkg::*;

  localparam int IDLE_PCT     = 29;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BODY, ST_ESCAPE, ST_RUNLEN, ST_END, ST_CHECKSUM
  } frame_phase_t;

  class deframe_scoreboard;
    frame_phase_t phase;
    logic [7:0]   running_sum;
    logic [3:0]   high_nibble;
    logic [7:0]   last_byte;
    bit           body_seen;
    rpd_evt_t     pending_events[$];
    int           failures;
    int           kind_count[4];
    int           good_ends;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      phase       = ST_IDLE;
      running_sum = 8'h00;
      high_nibble = 4'h0;
      last_byte   = 8'h00;
      body_seen   = 1'b0;
    endfunction

    static function bit decode_hex(input logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= CH_0 && c <= CH_9) v = 4'(c - CH_0);
      else if (c >= CH_UA && c <= CH_UF) v = 4'(c - CH_UA + HEX_TEN);
      else if (c >= CH_LA && c <= CH_LF) v = 4'(c - CH_LA + HEX_TEN);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void add_event(logic [1:0] kind, logic [7:0] data, logic [7:0] count,
                            logic ok);
      rpd_evt_t e;
      e.kind  = kind;
      e.data  = data;
      e.count = count;
      e.ok    = ok;
      pending_events.push_back(e);
    endfunction

    // one accepted request
    function void note_byte(input logic [7:0] c);
      logic [3:0] v;
      int         n;
      logic       sum_match;
      if ((phase == ST_BODY && c != CH_HASH) || phase == ST_ESCAPE || phase == ST_RUNLEN)
        running_sum = running_sum + c;
      case (phase)
        ST_BODY: begin
          if (c == CH_RBRACE) phase = ST_ESCAPE;
          else if (c == CH_HASH) phase = ST_END;
          else if (c == CH_STAR) phase = ST_RUNLEN;
          else if (c > BODY_MAX) add_event(EV_UNEXPECTED, c, 8'd0, 1'b0);
          else begin
            last_byte = c;
            body_seen = 1'b1;
            add_event(EV_RUN, c, 8'd1, 1'b0);
          end
        end
        ST_ESCAPE: begin
          phase     = ST_BODY;
          last_byte = c ^ ESC_MASK;
          body_seen = 1'b1;
          add_event(EV_RUN, last_byte, 8'd1, 1'b0);
        end
        ST_RUNLEN: begin
          n     = int'(c) - int'(RUN_BIAS);
          phase = ST_BODY;
          if (n > 0 && body_seen) add_event(EV_RUN, last_byte, n[7:0], 1'b0);
        end
        ST_END: begin
          if (!decode_hex(c, v)) add_event(EV_UNEXPECTED, c, 8'd0, 1'b0);
          else begin
            high_nibble = v;
            phase       = ST_CHECKSUM;
          end
        end
        ST_CHECKSUM: begin
          if (!decode_hex(c, v)) add_event(EV_UNEXPECTED, c, 8'd0, 1'b0);
          else begin
            sum_match = ({high_nibble, v} == running_sum);
            clear_frame();
            add_event(EV_END, 8'd0, 8'd0, sum_match);
          end
        end
        default: begin
          if (c == CH_DOLLAR) phase = ST_BODY;
          else if (c == CH_BREAK) add_event(EV_BREAK, 8'd0, 8'd0, 1'b0);
          else if (c != CH_PLUS && c != CH_MINUS) add_event(EV_UNEXPECTED, c, 8'd0, 1'b0);
        end
      endcase
    endfunction

    // one accepted result
    function void check_event(logic [1:0] kind, logic [7:0] data, logic [7:0] count,
                              logic ok);
      rpd_evt_t e;
      if (pending_events.size() == 0) begin
        $error("event with nothing pending: kind %0d data %0h count %0d ok %0d",
               kind, data, count, ok);
        failures++;
        return;
      end
      e = pending_events.pop_front();
      kind_count[kind]++;
      if (kind == EV_END && ok) good_ends++;
      if (kind !== e.kind) begin
        $error("event_kind: expected %0d, actual %0d", e.kind, kind);
        failures++;
      end
      if (data !== e.data) begin
        $error("data_byte: expected %0h, actual %0h", e.data, data);
        failures++;
      end
      if (count !== e.count) begin
        $error("repeat_count: expected %0d, actual %0d", e.count, count);
        failures++;
      end
      if (ok !== e.ok) begin
        $error("checksum_ok: expected %0d, actual %0d", e.ok, ok);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte      = 8'h00;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [1:0] event_kind;
  logic [7:0] data_byte;
  logic [7:0] repeat_count;
  logic       checksum_ok;

  deframe_scoreboard sb = new();

  int         in_idle_pct  = IDLE_PCT;
  int         out_idle_pct = IDLE_PCT;
  bit         hold_req     = 1'b0;
  int         items_sent   = 0;
  logic [7:0] frame_sum    = 8'h00;

  rsp_packet_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .data_byte    (data_byte),
    .repeat_count (repeat_count),
    .checksum_ok  (checksum_ok)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_event(event_kind, data_byte, repeat_count, checksum_ok);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("rsp_packet_deframer: mismatch");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 10) return CH_0 + n;
    return (upper ? CH_UA : CH_LA) + n - HEX_TEN;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [3:0] v;
    do b = 8'($urandom_range(255)); while (deframe_scoreboard::decode_hex(b, v));
    return b;
  endfunction

  function automatic logic [7:0] plain_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(126)); while (b == CH_HASH || b == CH_RBRACE || b == CH_STAR);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit counts = 1'b1);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    if (counts) items_sent++;
  endtask

  task automatic send_framed(input logic [7:0] b);
    frame_sum = frame_sum + b;
    send_byte(b);
  endtask

  task automatic close_packet(input bit corrupt, input bit bad_hex);
    logic [7:0] sent_sum;
    send_byte(CH_HASH);
    sent_sum = corrupt ? frame_sum ^ (8'h01 << $urandom_range(7)) : frame_sum;
    if (bad_hex) send_byte(non_hex_byte());
    send_byte(hex_char(sent_sum[7:4], 1'($urandom_range(1))));
    if (bad_hex) send_byte(non_hex_byte());
    send_byte(hex_char(sent_sum[3:0], 1'($urandom_range(1))));
  endtask

  task automatic run_directed();
    send_byte(CH_PLUS, 1'b0);
    send_byte(CH_MINUS, 1'b0);
    send_byte(CH_BREAK);
    send_byte(8'h00);
    send_byte(8'hff);
    // runs, escape, high byte, dropped counts, bad digits
    send_byte(CH_DOLLAR);
    frame_sum = 8'h00;
    send_framed(8'h61);
    send_framed(CH_STAR);
    send_framed(8'd32);
    send_framed(CH_RBRACE);
    send_framed(8'h5d);
    send_framed(8'hff);
    send_framed(CH_STAR);
    send_framed(RUN_BIAS);
    send_framed(CH_STAR);
    send_framed(8'h00);
    send_framed(CH_STAR);
    send_framed(8'hff);
    close_packet(1'b0, 1'b1);
    // run on an empty body, wrong checksum
    send_byte(CH_DOLLAR);
    frame_sum = 8'h00;
    send_framed(CH_STAR);
    send_framed(8'd100);
    close_packet(1'b1, 1'b0);
  endtask

  task automatic send_packet();
    int body_len;
    int pick;
    body_len = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(10);
    send_byte(CH_DOLLAR);
    frame_sum = 8'h00;
    repeat (body_len) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        send_framed(CH_RBRACE);
        send_framed(8'($urandom_range(255)));
      end else if (pick == 1) begin
        send_framed(CH_STAR);
        send_framed(8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                : $urandom_range(30, 60)));
      end else if (pick == 2) begin
        send_framed(8'($urandom_range(127, 255)));
      end else begin
        send_framed(plain_body_byte());
      end
    end
    // a few packets are left open so the next one lands inside the body
    if ($urandom_range(19) != 0) close_packet($urandom_range(7) == 0, $urandom_range(9) == 0);
  endtask

  task automatic send_noise();
    int pick;
    pick = $urandom_range(5);
    if (pick == 0) send_byte(CH_PLUS, 1'b0);
    else if (pick == 1) send_byte(CH_MINUS, 1'b0);
    else if (pick == 2) send_byte(CH_BREAK);
    else send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_random(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(99) < 80) send_packet();
      else send_noise();
    end
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    base = items_sent;
    // back up the block behind a long output hold-off
    in_idle_pct = 0;
    hold_req    = 1'b1;
    send_random(base + 150);
    in_idle_pct = IDLE_PCT;
    send_random(base + 700);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random(base + 1000);
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    send_random(base + 1300);
    in_valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("deframer run: %0d counted requests; %0d body runs, %0d packet ends (%0d good)",
             items_sent, sb.kind_count[EV_RUN], sb.kind_count[EV_END], sb.good_ends);
    $display("deframer run: %0d breaks, %0d unexpected bytes, %0d field errors",
             sb.kind_count[EV_BREAK], sb.kind_count[EV_UNEXPECTED], sb.failures);
    if (sb.failures == 0) $display("rsp_packet_deframer: match");
    else $display("rsp_packet_deframer: mismatch");
    $finish;
  end

endmodule
